// File: design/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// Types and codes shared by the sorted priority queue top level and its cells.
// ----------------------------------------------------------------------------
package sspq_pkg;

	// action codes of the command word
	localparam logic [1:0] ACT_ENQ  = 2'd0;
	localparam logic [1:0] ACT_DEQ  = 2'd1;
	localparam logic [1:0] ACT_DISP = 2'd2;

	// status codes of the result word
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	localparam int FILL_W = 5;

	// command word
	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] item_value;
		logic signed [31:0] item_priority;
	} cmd_t;

	// result word
	typedef struct packed {
		logic [1:0]          status;
		logic signed [31:0]  out_value;
		logic signed [31:0]  out_priority;
		logic                last;
		logic [FILL_W-1:0]   fill_count;
	} rsp_t;

	// one stored pair
	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] prio;
	} entry_t;

	// per-cell move for this cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     occ;   // cell holds a live entry
		logic     tail;  // cell is the last live entry
	} cell_ctl_t;

endpackage

// File: design/sspq_cell.sv
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted chain: holds a pair and inserts, shifts or rotates it.
// ----------------------------------------------------------------------------
module sspq_cell (
	input  logic               clk,
	input  sspq_pkg::cell_ctl_t ctl,
	input  sspq_pkg::entry_t    new_item,
	input  sspq_pkg::entry_t    head_item,
	input  sspq_pkg::entry_t    left_item,
	input  sspq_pkg::entry_t    right_item,
	input  logic               left_le,
	output sspq_pkg::entry_t    item,
	output logic               le
);
	import sspq_pkg::*;

	entry_t item_q;
	entry_t item_d;

	// live entry that sorts at or before the new pair stays in front of it
	assign le = ctl.occ && ($signed(item_q.prio) <= $signed(new_item.prio));

	// next contents
	always_comb begin
		item_d = item_q;
		case (ctl.op)
			CELL_INSERT: begin
				if (!le) begin
					item_d = left_le ? new_item : left_item;
				end
			end
			CELL_SHIFT: begin
				item_d = right_item;
			end
			CELL_ROTATE: begin
				item_d = ctl.tail ? head_item : right_item;
			end
			default: begin
				item_d = item_q;
			end
		endcase
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		item_q <= item_d;
	end

	assign item = item_q;

endmodule

// File: design/stable_sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_top
// Stable sorted priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Enqueue and
// dequeue leave busy low: every cell compares its priority with the new
// one in parallel and the chain shifts at once, so a new command can follow
// in the next cycle. Display rotates the chain by one cell per cycle and
// emits the head each cycle, so it gives fill_count words (one on an empty
// queue) and holds busy high until the last word has been produced. Every
// result appears for exactly one cycle with strobe high, in the cycle after
// the command is taken (or after the previous display word); the receiver
// must take it then. Ties in priority are served first in, first out.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_top #(
	parameter int CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sspq_pkg::cmd_t cmd,
	output logic           strobe,
	output sspq_pkg::rsp_t rsp
);
	import sspq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] disp_left_q;
	logic             strobe_q;
	rsp_t             rsp_q;

	logic            accept;
	logic            full;
	logic            empty;
	entry_t          new_item;
	entry_t          cell_item [CAPACITY];
	logic [CAPACITY-1:0] cell_le;
	cell_op_t        op;

	assign busy     = (disp_left_q != '0);
	assign accept   = start && !busy;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign new_item = '{value: cmd.item_value, prio: cmd.item_priority};

	// chain move for this cycle
	always_comb begin
		op = CELL_HOLD;
		if (busy) begin
			op = CELL_ROTATE;
		end else if (accept) begin
			case (cmd.action)
				ACT_ENQ:  op = full  ? CELL_HOLD : CELL_INSERT;
				ACT_DEQ:  op = empty ? CELL_HOLD : CELL_SHIFT;
				ACT_DISP: op = empty ? CELL_HOLD : CELL_ROTATE;
				default:  op = CELL_HOLD;
			endcase
		end
	end

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.op   = op;
		assign ctl.occ  = (CNT_W'(i) < count_q);
		assign ctl.tail = (CNT_W'(i + 1) == count_q);

		sspq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_item   (new_item),
			.head_item  (cell_item[0]),
			.left_item  ((i == 0) ? new_item : cell_item[(i == 0) ? 0 : i - 1]),
			.right_item (cell_item[(i == CAPACITY - 1) ? i : i + 1]),
			.left_le    ((i == 0) ? 1'b1 : cell_le[(i == 0) ? 0 : i - 1]),
			.item       (cell_item[i]),
			.le         (cell_le[i])
		);
	end

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			disp_left_q <= '0;
			strobe_q    <= 1'b0;
			rsp_q       <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (busy) begin
				// display in progress: emit the current head
				strobe_q              <= 1'b1;
				disp_left_q           <= disp_left_q - CNT_W'(1);
				rsp_q.status          <= ST_OK;
				rsp_q.out_value       <= cell_item[0].value;
				rsp_q.out_priority    <= cell_item[0].prio;
				rsp_q.last            <= (disp_left_q == CNT_W'(1));
				rsp_q.fill_count      <= FILL_W'(count_q);
			end else if (accept) begin
				case (cmd.action)
					ACT_ENQ: begin
						strobe_q           <= 1'b1;
						rsp_q.out_value    <= cmd.item_value;
						rsp_q.out_priority <= cmd.item_priority;
						rsp_q.last         <= 1'b1;
						if (full) begin
							rsp_q.status     <= ST_OVERFLOW;
							rsp_q.fill_count <= FILL_W'(count_q);
						end else begin
							rsp_q.status     <= ST_OK;
							count_q          <= count_q + CNT_W'(1);
							rsp_q.fill_count <= FILL_W'(count_q + CNT_W'(1));
						end
					end
					ACT_DEQ: begin
						strobe_q   <= 1'b1;
						rsp_q.last <= 1'b1;
						if (empty) begin
							rsp_q.status       <= ST_UNDERFLOW;
							rsp_q.out_value    <= '0;
							rsp_q.out_priority <= '0;
							rsp_q.fill_count   <= '0;
						end else begin
							rsp_q.status       <= ST_OK;
							rsp_q.out_value    <= cell_item[0].value;
							rsp_q.out_priority <= cell_item[0].prio;
							count_q            <= count_q - CNT_W'(1);
							rsp_q.fill_count   <= FILL_W'(count_q - CNT_W'(1));
						end
					end
					ACT_DISP: begin
						strobe_q         <= 1'b1;
						rsp_q.fill_count <= FILL_W'(count_q);
						if (empty) begin
							rsp_q.status       <= ST_EMPTY;
							rsp_q.out_value    <= '0;
							rsp_q.out_priority <= '0;
							rsp_q.last         <= 1'b1;
						end else begin
							rsp_q.status       <= ST_OK;
							rsp_q.out_value    <= cell_item[0].value;
							rsp_q.out_priority <= cell_item[0].prio;
							rsp_q.last         <= (count_q == CNT_W'(1));
							disp_left_q        <= count_q - CNT_W'(1);
						end
					end
					default: begin
						strobe_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	// assertions
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_busy_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> strobe)
		else $error("display in progress without a result word");

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !rsp.last) |-> busy)
		else $error("non-final result with no display in progress");

	a_fill_match: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (rsp.fill_count == FILL_W'(count_q)))
		else $error("reported fill count differs from stored count");

	a_disp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		disp_left_q < count_q || disp_left_q == '0)
		else $error("display counter exceeds entry count");

endmodule

// File: bench/tb_stable_sorted_priority_queue_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_sorted_priority_queue_top
// Self-checking bench for the stable sorted priority queue.
// ----------------------------------------------------------------------------
// Command words go in through the start/busy handshake. Each accepted word is
// also applied to a shadow copy of the queue, which works out the result
// words the block must produce. A monitor takes every strobed result word and
// compares it field by field with the oldest pending prediction. The run
// covers the empty-queue cases, the no-op action, a full queue with an
// overflowing enqueue, ties in priority, and a long stretch of random traffic
// that swings the fill level between empty and full.
// ----------------------------------------------------------------------------
module tb_stable_sorted_priority_queue_top;
	import sspq_pkg::*;

	localparam int CAP        = 16;
	localparam int LIMIT      = 200000;
	localparam int RAND_WORDS = 445;
	localparam int CALM_TAIL  = 60;
	localparam int SETTLE     = 20;
	localparam logic [1:0] ACT_NOP = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic strobe;
	rsp_t rsp;

	// shadow copy of the queue contents
	logic signed [31:0] shadow_value [CAP];
	logic signed [31:0] shadow_prio  [CAP];
	int                 shadow_count;

	rsp_t awaited_rsps[$];
	int   mismatches;
	int   cycles;

	stable_sorted_priority_queue_top #(
		.CAPACITY(CAP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.strobe(strobe),
		.rsp   (rsp)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL stable_sorted_priority_queue_top");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(input logic [1:0] act, input logic [31:0] v,
			input logic [31:0] p);
		cmd_t w;
		w.action        = act;
		w.item_value    = v;
		w.item_priority = p;
		return w;
	endfunction

	// apply one accepted word to the shadow queue, queue up its result words
	task automatic apply_to_shadow_queue(input cmd_t w);
		rsp_t r;
		int   pos;
		r = '0;
		r.last = 1'b1;
		case (w.action)
		ACT_ENQ: begin
			if (shadow_count >= CAP) begin
				r.status       = ST_OVERFLOW;
				r.out_value    = w.item_value;
				r.out_priority = w.item_priority;
			end else begin
				// insert behind every entry of equal or lower priority number
				pos = 0;
				while (pos < shadow_count &&
						$signed(shadow_prio[pos]) <= $signed(w.item_priority))
					pos++;
				for (int i = shadow_count; i > pos; i--) begin
					shadow_value[i] = shadow_value[i-1];
					shadow_prio[i]  = shadow_prio[i-1];
				end
				shadow_value[pos] = w.item_value;
				shadow_prio[pos]  = w.item_priority;
				shadow_count++;
				r.status       = ST_OK;
				r.out_value    = w.item_value;
				r.out_priority = w.item_priority;
			end
			r.fill_count = shadow_count[FILL_W-1:0];
			awaited_rsps.push_back(r);
		end
		ACT_DEQ: begin
			if (shadow_count == 0) begin
				r.status = ST_UNDERFLOW;
			end else begin
				r.status       = ST_OK;
				r.out_value    = shadow_value[0];
				r.out_priority = shadow_prio[0];
				for (int i = 1; i < shadow_count; i++) begin
					shadow_value[i-1] = shadow_value[i];
					shadow_prio[i-1]  = shadow_prio[i];
				end
				shadow_count--;
			end
			r.fill_count = shadow_count[FILL_W-1:0];
			awaited_rsps.push_back(r);
		end
		ACT_DISP: begin
			if (shadow_count == 0) begin
				r.status     = ST_EMPTY;
				r.fill_count = '0;
				awaited_rsps.push_back(r);
			end else begin
				for (int i = 0; i < shadow_count; i++) begin
					r.status       = ST_OK;
					r.out_value    = shadow_value[i];
					r.out_priority = shadow_prio[i];
					r.last         = (i == shadow_count - 1);
					r.fill_count   = shadow_count[FILL_W-1:0];
					awaited_rsps.push_back(r);
				end
			end
		end
		default: ; // no-op code: nothing happens
		endcase
	endtask

	// drive one word from a falling edge until accepted; start stays high
	task automatic send_word(input cmd_t w);
		start <= 1'b1;
		cmd   <= w;
		do @(posedge clk); while (busy);
		apply_to_shadow_queue(w);
		@(negedge clk);
	endtask

	task automatic idle_burst(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t exp_w;
		if (arst_n && strobe) begin
			if (awaited_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("cycle %0d: unexpected result word st=%0d val=%0d pri=%0d",
						cycles, rsp.status, rsp.out_value, rsp.out_priority);
			end else begin
				exp_w = awaited_rsps.pop_front();
				if (rsp.status !== exp_w.status || rsp.out_value !== exp_w.out_value ||
						rsp.out_priority !== exp_w.out_priority ||
						rsp.last !== exp_w.last || rsp.fill_count !== exp_w.fill_count) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("cycle %0d: expected st=%0d val=%0d pri=%0d last=%0b fill=%0d",
							cycles, exp_w.status, exp_w.out_value, exp_w.out_priority,
							exp_w.last, exp_w.fill_count);
						$display("cycle %0d:      got st=%0d val=%0d pri=%0d last=%0b fill=%0d",
							cycles, rsp.status, rsp.out_value, rsp.out_priority,
							rsp.last, rsp.fill_count);
					end
				end
			end
		end
	end

	// underflow, empty display and the no-op code on an empty queue
	task automatic test_empty_queue();
		send_word(make_cmd(ACT_DEQ, 32'h1234_5678, 32'h8765_4321));
		send_word(make_cmd(ACT_DISP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_word(make_cmd(ACT_NOP, 32'hDEAD_BEEF, 32'h0000_0001));
		send_word(make_cmd(ACT_DEQ, '0, '0));
	endtask

	// fill with extreme and tied priorities, overflow, list, pop tied heads
	task automatic test_sorted_fill();
		send_word(make_cmd(ACT_ENQ, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_word(make_cmd(ACT_ENQ, 32'h8000_0000, 32'h8000_0000));
		send_word(make_cmd(ACT_ENQ, 32'h0000_0000, 32'h0000_0000));
		send_word(make_cmd(ACT_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_word(make_cmd(ACT_ENQ, 32'hAAAA_AAAA, 32'h0000_0001));
		send_word(make_cmd(ACT_ENQ, 32'h5555_5555, 32'h8000_0000));
		send_word(make_cmd(ACT_ENQ, 32'h0000_0001, 32'h0000_0005));
		send_word(make_cmd(ACT_ENQ, 32'h0000_0002, 32'h0000_0005));
		send_word(make_cmd(ACT_ENQ, 32'h0000_0003, 32'h0000_0005));
		send_word(make_cmd(ACT_ENQ, 32'h1111_1111, 32'h7FFF_FFFF));
		send_word(make_cmd(ACT_ENQ, 32'h2222_2222, 32'hFFFF_FFFE));
		send_word(make_cmd(ACT_ENQ, 32'h3333_3333, 32'h0000_0005));
		send_word(make_cmd(ACT_ENQ, 32'h4444_4444, 32'h0000_0000));
		send_word(make_cmd(ACT_ENQ, 32'hCCCC_CCCC, 32'hAAAA_AAAA));
		send_word(make_cmd(ACT_ENQ, 32'h3333_CCCC, 32'h5555_5555));
		send_word(make_cmd(ACT_ENQ, 32'h8000_0001, 32'h8000_0000));
		// queue is full now: this one is dropped and echoed
		send_word(make_cmd(ACT_ENQ, 32'h0BAD_F00D, 32'h8000_0000));
		send_word(make_cmd(ACT_DISP, '0, '0));
		send_word(make_cmd(ACT_DEQ, '0, '0));
		send_word(make_cmd(ACT_DEQ, '0, '0));
	endtask

	// small priority range for ties half the time, with some full-range and extremes
	function automatic logic [31:0] pick_priority();
		case ($urandom_range(0, 7))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2, 3: return $urandom();
		default: return 32'($urandom_range(0, 7)) - 32'd4;
		endcase
	endfunction

	// random traffic in phases that lean toward filling or draining
	task automatic test_random_traffic();
		int         sent;
		int         phase_len;
		int         enq_pct;
		int         roll;
		bit         idle_on;
		logic [1:0] act;
		sent = 0;
		while (sent < RAND_WORDS) begin
			phase_len = $urandom_range(20, 50);
			case ($urandom_range(0, 3))
			0: enq_pct = 85;
			1: enq_pct = 20;
			2: enq_pct = 50;
			default: enq_pct = $urandom_range(5, 95);
			endcase
			idle_on = ($urandom_range(0, 2) != 0);
			for (int k = 0; k < phase_len && sent < RAND_WORDS; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					act = ACT_NOP;
				else if (roll < 10)
					act = ACT_DISP;
				else if ($urandom_range(0, 99) < enq_pct)
					act = ACT_ENQ;
				else
					act = ACT_DEQ;
				if (idle_on && RAND_WORDS - sent > CALM_TAIL && $urandom_range(0, 9) < 3)
					idle_burst($urandom_range(1, 4));
				send_word(make_cmd(act, $urandom(), pick_priority()));
				if (act != ACT_NOP)
					sent++;
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		mismatches   = 0;
		cycles       = 0;
		shadow_count = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_queue();
		test_sorted_fill();
		test_random_traffic();

		// drain: wait for every predicted word, then a short settle
		start <= 1'b0;
		while (awaited_rsps.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && awaited_rsps.size() == 0)
			$display("PASS stable_sorted_priority_queue_top");
		else
			$display("FAIL stable_sorted_priority_queue_top");
		$finish;
	end

endmodule

// File: stable_sorted_priority_queue_top.f
design/sspq_pkg.sv
design/sspq_cell.sv
design/stable_sorted_priority_queue_top.sv
bench/tb_stable_sorted_priority_queue_top.sv
